// ===== design/kbd_pkg.sv =====
// Shared constants and scan code lookup tables for the scan-code-set-1 decoder.
`default_nettype none
package kbd_pkg;

    localparam int CODE_W  = 8;
    localparam int KEY_W   = 7;
    localparam int ASCII_W = 7;

    localparam logic [CODE_W-1:0]  KEY_PREFIX = 8'hE0;
    localparam logic [CODE_W-1:0]  KEY_BREAK  = 8'h80;
    localparam logic [KEY_W-1:0]   KEY_MASK   = 7'h7F;
    localparam logic [KEY_W-1:0]   KEY_CTRL   = 7'h1D;
    localparam logic [KEY_W-1:0]   KEY_LSHIFT = 7'h2A;
    localparam logic [KEY_W-1:0]   KEY_RSHIFT = 7'h36;
    localparam logic [KEY_W-1:0]   KEY_CAPS   = 7'h3A;

    localparam logic [ASCII_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [ASCII_W-1:0] CHAR_LOWER_Z = 7'h7A;
    localparam logic [ASCII_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [ASCII_W-1:0] CHAR_UPPER_Z = 7'h5A;
    localparam logic [ASCII_W-1:0] CASE_OFFSET  = 7'h20;
    localparam logic [ASCII_W-1:0] CTRL_OFFSET  = 7'h60;

    // Unshifted layout; zero marks a key with no character.
    function automatic logic [ASCII_W-1:0] plain_lookup(input logic [KEY_W-1:0] key);
        logic [ASCII_W-1:0] ch;
        case (key)
            7'h01: ch = 7'h1B;
            7'h02: ch = 7'h31; 7'h03: ch = 7'h32; 7'h04: ch = 7'h33; 7'h05: ch = 7'h34;
            7'h06: ch = 7'h35; 7'h07: ch = 7'h36; 7'h08: ch = 7'h37; 7'h09: ch = 7'h38;
            7'h0A: ch = 7'h39; 7'h0B: ch = 7'h30; 7'h0C: ch = 7'h2D; 7'h0D: ch = 7'h3D;
            7'h0E: ch = 7'h08; 7'h0F: ch = 7'h09;
            7'h10: ch = 7'h71; 7'h11: ch = 7'h77; 7'h12: ch = 7'h65; 7'h13: ch = 7'h72;
            7'h14: ch = 7'h74; 7'h15: ch = 7'h79; 7'h16: ch = 7'h75; 7'h17: ch = 7'h69;
            7'h18: ch = 7'h6F; 7'h19: ch = 7'h70; 7'h1A: ch = 7'h5B; 7'h1B: ch = 7'h5D;
            7'h1C: ch = 7'h0A;
            7'h1E: ch = 7'h61; 7'h1F: ch = 7'h73; 7'h20: ch = 7'h64; 7'h21: ch = 7'h66;
            7'h22: ch = 7'h67; 7'h23: ch = 7'h68; 7'h24: ch = 7'h6A; 7'h25: ch = 7'h6B;
            7'h26: ch = 7'h6C; 7'h27: ch = 7'h3B; 7'h28: ch = 7'h27; 7'h29: ch = 7'h60;
            7'h2B: ch = 7'h5C;
            7'h2C: ch = 7'h7A; 7'h2D: ch = 7'h78; 7'h2E: ch = 7'h63; 7'h2F: ch = 7'h76;
            7'h30: ch = 7'h62; 7'h31: ch = 7'h6E; 7'h32: ch = 7'h6D; 7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E; 7'h35: ch = 7'h2F; 7'h39: ch = 7'h20;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    // Layout with shift held; zero marks a key with no character.
    function automatic logic [ASCII_W-1:0] shifted_lookup(input logic [KEY_W-1:0] key);
        logic [ASCII_W-1:0] ch;
        case (key)
            7'h02: ch = 7'h21; 7'h03: ch = 7'h40; 7'h04: ch = 7'h23; 7'h05: ch = 7'h24;
            7'h06: ch = 7'h25; 7'h07: ch = 7'h5E; 7'h08: ch = 7'h26; 7'h09: ch = 7'h2A;
            7'h0A: ch = 7'h28; 7'h0B: ch = 7'h29; 7'h0C: ch = 7'h5F; 7'h0D: ch = 7'h2B;
            7'h10: ch = 7'h51; 7'h11: ch = 7'h57; 7'h12: ch = 7'h45; 7'h13: ch = 7'h52;
            7'h14: ch = 7'h54; 7'h15: ch = 7'h59; 7'h16: ch = 7'h55; 7'h17: ch = 7'h49;
            7'h18: ch = 7'h4F; 7'h19: ch = 7'h50; 7'h1A: ch = 7'h7B; 7'h1B: ch = 7'h7D;
            7'h1E: ch = 7'h41; 7'h1F: ch = 7'h53; 7'h20: ch = 7'h44; 7'h21: ch = 7'h46;
            7'h22: ch = 7'h47; 7'h23: ch = 7'h48; 7'h24: ch = 7'h4A; 7'h25: ch = 7'h4B;
            7'h26: ch = 7'h4C; 7'h27: ch = 7'h3A; 7'h28: ch = 7'h22; 7'h29: ch = 7'h7E;
            7'h2B: ch = 7'h7C;
            7'h2C: ch = 7'h5A; 7'h2D: ch = 7'h58; 7'h2E: ch = 7'h43; 7'h2F: ch = 7'h56;
            7'h30: ch = 7'h42; 7'h31: ch = 7'h4E; 7'h32: ch = 7'h4D; 7'h33: ch = 7'h3C;
            7'h34: ch = 7'h3E; 7'h35: ch = 7'h3F; 7'h39: ch = 7'h20;
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// ===== design/keyboard_scancode_to_ascii_top.sv =====
// Scan-code-set-1 to ASCII decoder with modifier tracking.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) takes one raw scan code byte
//   per transaction. Master stream (m_tvalid/m_tready/m_tdata) gives one
//   ASCII character per transaction, in m_tdata[6:0] with bit 7 zero.
//   Prefix, modifier, caps lock, break and unmapped codes give no output
//   transaction; they only update the shift, ctrl, caps and prefix flags.
//   Path: a code is held in the input register, decoded combinationally,
//   and its character loaded into the result register that drives m_tvalid
//   (two register stages: input register, result register). Throughput:
//   one code per cycle while the result register is not stalled.
//   Reset (aresetn low, synchronous): both stages empty, all flags cleared.
//   Stall: while m_tready is low a full result register holds; the input
//   register still accepts one code, and further codes are refused once
//   both registers are full. Codes that give no output drain from the
//   input register only when the result register can advance, so order
//   of flag updates and characters is always kept.
`default_nettype none
module keyboard_scancode_to_ascii_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] scan_code
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [6:0] ascii_char, [7] zero
);

    logic                           in_valid_reg;
    logic [kbd_pkg::CODE_W-1:0]     in_code_reg;
    logic                           out_valid_reg;
    logic [kbd_pkg::ASCII_W-1:0]    out_char_reg;

    logic lshift_reg, rshift_reg, lctrl_reg, rctrl_reg, caps_reg, prefix_reg;
    logic lshift_next, rshift_next, lctrl_next, rctrl_next, caps_next, prefix_next;

    logic                           advance;
    logic [kbd_pkg::KEY_W-1:0]      key;
    logic                           make;
    logic                           shift;
    logic                           emit;
    logic [kbd_pkg::ASCII_W-1:0]    base;
    logic [kbd_pkg::ASCII_W-1:0]    ch;
    logic [kbd_pkg::ASCII_W-1:0]    char_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};

    assign key   = in_code_reg[kbd_pkg::KEY_W-1:0] & kbd_pkg::KEY_MASK;
    assign make  = (in_code_reg & kbd_pkg::KEY_BREAK) == '0;
    assign shift = lshift_reg || rshift_reg;

    always_comb begin
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        lctrl_next  = lctrl_reg;
        rctrl_next  = rctrl_reg;
        caps_next   = caps_reg;
        prefix_next = prefix_reg;
        emit        = 1'b0;
        base        = kbd_pkg::plain_lookup(key);
        ch          = '0;
        char_next   = '0;
        if (in_code_reg == kbd_pkg::KEY_PREFIX) begin
            prefix_next = 1'b1;
        end else if (prefix_reg) begin
            // extended codes only matter for right ctrl
            prefix_next = 1'b0;
            if (key == kbd_pkg::KEY_CTRL) begin
                rctrl_next = make;
            end
        end else if (key == kbd_pkg::KEY_LSHIFT) begin
            lshift_next = make;
        end else if (key == kbd_pkg::KEY_RSHIFT) begin
            rshift_next = make;
        end else if (key == kbd_pkg::KEY_CTRL) begin
            lctrl_next = make;
        end else if (key == kbd_pkg::KEY_CAPS) begin
            if (make) begin
                caps_next = !caps_reg;
            end
        end else if (make) begin
            if (lctrl_reg || rctrl_reg) begin
                // letters in the plain layout are lower-case only
                if (base >= kbd_pkg::CHAR_LOWER_A && base <= kbd_pkg::CHAR_LOWER_Z) begin
                    char_next = base - kbd_pkg::CTRL_OFFSET;
                end
            end else begin
                ch = shift ? kbd_pkg::shifted_lookup(key) : base;
                if (caps_reg && ch >= kbd_pkg::CHAR_LOWER_A && ch <= kbd_pkg::CHAR_LOWER_Z) begin
                    char_next = ch - kbd_pkg::CASE_OFFSET;
                end else if (caps_reg && shift && ch >= kbd_pkg::CHAR_UPPER_A
                             && ch <= kbd_pkg::CHAR_UPPER_Z) begin
                    char_next = ch + kbd_pkg::CASE_OFFSET;
                end else begin
                    char_next = ch;
                end
            end
            emit = char_next != '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lshift_reg    <= 1'b0;
            rshift_reg    <= 1'b0;
            lctrl_reg     <= 1'b0;
            rctrl_reg     <= 1'b0;
            caps_reg      <= 1'b0;
            prefix_reg    <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_code_reg  <= s_tdata;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                lshift_reg <= lshift_next;
                rshift_reg <= rshift_next;
                lctrl_reg  <= lctrl_next;
                rctrl_reg  <= rctrl_next;
                caps_reg   <= caps_next;
                prefix_reg <= prefix_next;
            end
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
                out_char_reg  <= char_next;
            end else if (m_tready) begin
                // drop the result once taken
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_nonzero_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:0] != '0)
        else $error("zero character presented");

    a_prefix_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_code_reg == kbd_pkg::KEY_PREFIX |=> prefix_reg)
        else $error("prefix flag not set after prefix code");

    a_prefix_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && prefix_reg && in_code_reg != kbd_pkg::KEY_PREFIX
        |=> !prefix_reg && !(out_valid_reg && !$past(out_valid_reg)))
        else $error("extended code not consumed");

    a_no_emit_on_break: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !make |-> !emit)
        else $error("break code produced a character");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_keyboard_scancode_to_ascii_top.sv =====
// Self-checking stream testbench for the scan-code-set-1 to ASCII decoder.
`timescale 1ns / 100ps

module tb_keyboard_scancode_to_ascii_top;

    localparam int QUIET_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int PHASE_ITEMS     = 430;
    localparam int OPENING_LEN     = 28;

    // Characters that the row strings below cannot carry
    localparam logic [6:0] CHAR_ESC   = 7'h1B;
    localparam logic [6:0] CHAR_BS    = 7'h08;
    localparam logic [6:0] CHAR_TAB   = 7'h09;
    localparam logic [6:0] CHAR_LF    = 7'h0A;
    localparam logic [6:0] CHAR_GRAVE = 7'h60;
    localparam logic [6:0] CHAR_TILDE = 7'h7E;

    class char_scoreboard;
        bit         lshift, rshift, lctrl, rctrl, caps_on, prefix_seen;
        logic [6:0] plain_chars [128];
        logic [6:0] shift_chars [128];
        logic [6:0] due_chars [$];
        int         errors;

        function new();
            foreach (plain_chars[i]) begin
                plain_chars[i] = '0;
                shift_chars[i] = '0;
            end
            fill_row(8'h02, "1234567890-=", "!@#$%^&*()_+");
            fill_row(8'h10, "qwertyuiop[]", "QWERTYUIOP{}");
            fill_row(8'h1E, "asdfghjkl;'", "ASDFGHJKL:\"");
            fill_row(8'h2B, "\\zxcvbnm,./", "|ZXCVBNM<>?");
            fill_row(8'h39, " ", " ");
            plain_chars[7'h01] = CHAR_ESC;
            plain_chars[7'h0E] = CHAR_BS;
            plain_chars[7'h0F] = CHAR_TAB;
            plain_chars[7'h1C] = CHAR_LF;
            plain_chars[7'h29] = CHAR_GRAVE;
            shift_chars[7'h29] = CHAR_TILDE;
            errors = 0;
        endfunction

        function void fill_row(int first, string lo, string hi);
            byte c;
            for (int i = 0; i < lo.len(); i++) begin
                c = lo[i];
                plain_chars[first + i] = c[6:0];
                c = hi[i];
                shift_chars[first + i] = c[6:0];
            end
        endfunction

        function bit is_lower(logic [6:0] c);
            return c >= kbd_pkg::CHAR_LOWER_A && c <= kbd_pkg::CHAR_LOWER_Z;
        endfunction

        function bit is_upper(logic [6:0] c);
            return c >= kbd_pkg::CHAR_UPPER_A && c <= kbd_pkg::CHAR_UPPER_Z;
        endfunction

        // Update the key state for one accepted code and queue its character
        function void note_code(logic [7:0] code);
            logic [6:0] key;
            logic [6:0] base;
            logic [6:0] ch;
            bit         make;
            bit         shifted;
            key  = code[6:0];
            make = !code[7];
            ch   = '0;
            if (code == kbd_pkg::KEY_PREFIX) begin
                prefix_seen = 1'b1;
                return;
            end
            if (prefix_seen) begin
                prefix_seen = 1'b0;
                if (key == kbd_pkg::KEY_CTRL)
                    rctrl = make;
                return;
            end
            if (key == kbd_pkg::KEY_LSHIFT) begin
                lshift = make;
                return;
            end
            if (key == kbd_pkg::KEY_RSHIFT) begin
                rshift = make;
                return;
            end
            if (key == kbd_pkg::KEY_CTRL) begin
                lctrl = make;
                return;
            end
            if (key == kbd_pkg::KEY_CAPS) begin
                if (make)
                    caps_on = !caps_on;
                return;
            end
            if (!make)
                return;
            shifted = lshift || rshift;
            if (lctrl || rctrl) begin
                base = plain_chars[key];
                if (is_lower(base))
                    ch = base - kbd_pkg::CHAR_LOWER_A + 7'd1;
                else if (is_upper(base))
                    ch = base - kbd_pkg::CHAR_UPPER_A + 7'd1;
            end else begin
                ch = shifted ? shift_chars[key] : plain_chars[key];
                if (caps_on && is_lower(ch))
                    ch = ch - kbd_pkg::CHAR_LOWER_A + kbd_pkg::CHAR_UPPER_A;
                else if (caps_on && shifted && is_upper(ch))
                    ch = ch - kbd_pkg::CHAR_UPPER_A + kbd_pkg::CHAR_LOWER_A;
            end
            if (ch != '0)
                due_chars.push_back(ch);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("%0t ns: mismatch: %s", $time, what);
        endtask

        task check_char(logic [7:0] data);
            logic [6:0] want;
            if (due_chars.size() == 0) begin
                report($sformatf("character %02h with none outstanding", data));
                return;
            end
            want = due_chars.pop_front();
            if (data[6:0] !== want)
                report($sformatf("ascii_char %02h, wanted %02h", data[6:0], want));
            if (data[7] !== 1'b0)
                report($sformatf("pad bit set in %02h", data));
        endtask

        function int pending();
            return due_chars.size();
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] scan_code
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;            // [6:0] ascii_char, [7] zero

    char_scoreboard chars = new();
    int  idle_pct     = 0;
    int  stall_pct    = 0;
    int  items_sent   = 0;
    int  quiet_cycles = 0;
    bit  hold_off_req = 1'b0;
    logic [7:0] opening_codes [OPENING_LEN];

    keyboard_scancode_to_ascii_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                chars.note_code(s_tdata);
            if (m_tvalid && m_tready)
                chars.check_char(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [7:0] make_of(logic [6:0] key);
        return {1'b0, key};
    endfunction

    function automatic logic [7:0] break_of(logic [6:0] key);
        return kbd_pkg::KEY_BREAK | {1'b0, key};
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic logic [6:0] rand_key();
        logic [31:0] r;
        if ($urandom_range(99) < 80)
            r = $urandom_range(8'h39, 1);
        else
            r = $urandom_range(8'h7F, 0);
        return r[6:0];
    endfunction

    task automatic send_code(input logic [7:0] code);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    // Hold the input until every character has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chars.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Press some modifiers, type a few keys, release the modifiers
    task automatic type_chord();
        bit         use_ls, use_rs, use_lc, use_rc;
        logic [6:0] key;
        use_ls = $urandom_range(99) < 30;
        use_rs = $urandom_range(99) < 15;
        use_lc = $urandom_range(99) < 12;
        use_rc = $urandom_range(99) < 8;
        if (use_ls)
            send_code(make_of(kbd_pkg::KEY_LSHIFT));
        if (use_rs)
            send_code(make_of(kbd_pkg::KEY_RSHIFT));
        if (use_lc)
            send_code(make_of(kbd_pkg::KEY_CTRL));
        if (use_rc) begin
            send_code(kbd_pkg::KEY_PREFIX);
            send_code(make_of(kbd_pkg::KEY_CTRL));
        end
        repeat ($urandom_range(4, 1)) begin
            key = rand_key();
            send_code(make_of(key));
            send_code(break_of(key));
        end
        if (use_rc) begin
            send_code(kbd_pkg::KEY_PREFIX);
            send_code(break_of(kbd_pkg::KEY_CTRL));
        end
        if (use_lc)
            send_code(break_of(kbd_pkg::KEY_CTRL));
        if (use_rs)
            send_code(break_of(kbd_pkg::KEY_RSHIFT));
        if (use_ls)
            send_code(break_of(kbd_pkg::KEY_LSHIFT));
    endtask

    task automatic type_step();
        int         pick;
        logic [6:0] modifier;
        pick = $urandom_range(99);
        if (pick < 60) begin
            type_chord();
        end else if (pick < 75) begin
            send_code(rand_byte());
        end else if (pick < 82) begin
            send_code(kbd_pkg::KEY_PREFIX);
            send_code(rand_byte());
        end else if (pick < 88) begin
            send_code(make_of(kbd_pkg::KEY_CAPS));
            send_code(break_of(kbd_pkg::KEY_CAPS));
        end else begin
            case ($urandom_range(2))
                0: modifier = kbd_pkg::KEY_LSHIFT;
                1: modifier = kbd_pkg::KEY_RSHIFT;
                default: modifier = kbd_pkg::KEY_CTRL;
            endcase
            send_code(($urandom_range(99) < 30) ? make_of(modifier) : break_of(modifier));
        end
    endtask

    task automatic type_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
            type_step();
    endtask

    initial begin
        opening_codes = '{
            // field extremes
            8'h00, 8'hFF, 8'h7F, 8'h80,
            // plain letter
            8'h1E,
            // shifted letter
            make_of(kbd_pkg::KEY_LSHIFT), 8'h1E,
            // caps with shift
            make_of(kbd_pkg::KEY_CAPS), 8'h1E,
            // caps release ignored
            break_of(kbd_pkg::KEY_LSHIFT), break_of(kbd_pkg::KEY_CAPS), 8'h1E,
            // shifted digit
            make_of(kbd_pkg::KEY_RSHIFT), 8'h02, break_of(kbd_pkg::KEY_RSHIFT),
            // caps off again
            make_of(kbd_pkg::KEY_CAPS),
            // control character
            make_of(kbd_pkg::KEY_CTRL), 8'h2E, break_of(kbd_pkg::KEY_CTRL),
            // repeated prefix, right ctrl
            kbd_pkg::KEY_PREFIX, kbd_pkg::KEY_PREFIX, make_of(kbd_pkg::KEY_CTRL),
            8'h2C,
            kbd_pkg::KEY_PREFIX, break_of(kbd_pkg::KEY_CTRL),
            // extended key swallowed
            kbd_pkg::KEY_PREFIX, 8'h1E,
            // escape
            8'h01
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening_codes[i])
            send_code(opening_codes[i]);
        drain_results();

        // No idling, with one long hold-off on the result side
        type_random(PHASE_ITEMS / 2);
        hold_off_req = 1'b1;
        type_random(40);
        drain_results();
        type_random(PHASE_ITEMS / 2);

        idle_pct  = 69;
        stall_pct = 0;
        type_random(PHASE_ITEMS);
        drain_results();

        idle_pct  = 0;
        stall_pct = 69;
        type_random(PHASE_ITEMS);

        idle_pct  = 38;
        stall_pct = 38;
        type_random(PHASE_ITEMS);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (chars.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
